>>> design/pid_dd_pkg.sv
// shared types, widths and a helper function for the differential drive pid block
// no dependencies

package pid_dd_pkg;

  // field widths
  localparam int unsigned ErrW  = 16;
  localparam int unsigned SumW  = 32;
  localparam int unsigned DiffW = 17;
  localparam int unsigned SpdW  = 8;
  localparam int unsigned GainW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // product and accumulation widths, all exact
  localparam int unsigned PProdW = ErrW + GainW;     // 32
  localparam int unsigned IProdW = SumW + GainW;     // 48
  localparam int unsigned DProdW = DiffW + GainW;    // 33
  localparam int unsigned CorrW  = IProdW + 1;       // 49
  localparam int unsigned DutyW  = CorrW + 2;        // 51
  localparam int unsigned FracW  = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_SPEED = 3'd0,
    CFG_MAX_SPEED  = 3'd1,
    CFG_GAIN_P     = 3'd2,
    CFG_GAIN_I     = 3'd3,
    CFG_GAIN_D     = 3'd4
  } cfg_idx_e;

  // clamp a q.16 duty to 0..max and drop the fraction
  function automatic logic [SpdW-1:0] duty_clamp(input logic signed [DutyW-1:0] v,
                                                 input logic [SpdW-1:0] max_spd);
    logic signed [DutyW-1:0] lim;
    logic [SpdW-1:0] res;
    lim = $signed({{(DutyW-SpdW-FracW){1'b0}}, max_spd, {FracW{1'b0}}});
    if (v <= 0) begin
      res = '0;
    end else if (v >= lim) begin
      res = max_spd;
    end else begin
      res = v[FracW+SpdW-1:FracW];
    end
    return res;
  endfunction

endpackage

>>> design/pid_differential_drive.sv
// differential drive pid controller: integral, derivative, gains and wheel duty clamp
// depends on pid_dd_pkg

// each accepted error passes the input register and then the result register
// throughput: one error transaction per cycle unless the input stalls; the input register
// feeds the products, correction and duty clamp in one combinational pass into the result
// register; the input stalls only while both registers hold a transaction and the output
// is stalled; reset clears the running sum, the previous error and both valid bits, and
// loads the registers with base 0, max 255 and zero gains
module pid_differential_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // error channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pid_dd_pkg::ErrW-1:0]   error_i,
  // duty channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pid_dd_pkg::SpdW-1:0]          left_speed_o,
  output logic [pid_dd_pkg::SpdW-1:0]          right_speed_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pid_dd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [pid_dd_pkg::CfgDataW-1:0]      cfg_data_i
);

  // configuration registers
  logic [pid_dd_pkg::SpdW-1:0]         base_q, max_q;
  logic signed [pid_dd_pkg::GainW-1:0] gain_p_q, gain_i_q, gain_d_q;

  // controller state
  logic signed [pid_dd_pkg::SumW-1:0] error_sum_q, error_sum_d;
  logic signed [pid_dd_pkg::ErrW-1:0] prev_error_q;

  // input and result registers
  logic                                s1_valid_q, out_valid_q;
  logic signed [pid_dd_pkg::ErrW-1:0]  s1_err_q;
  logic signed [pid_dd_pkg::SumW-1:0]  s1_sum_q;
  logic signed [pid_dd_pkg::DiffW-1:0] s1_diff_q, s1_diff_d;
  logic [pid_dd_pkg::SpdW-1:0]          left_q, left_d, right_q, right_d;

  // combinational terms
  logic signed [pid_dd_pkg::PProdW-1:0] p_prod;
  logic signed [pid_dd_pkg::IProdW-1:0] i_prod;
  logic signed [pid_dd_pkg::DProdW-1:0] d_prod;
  logic signed [pid_dd_pkg::CorrW-1:0]  corr;

  // stage handshake
  logic out_free, s1_move, s1_load, accept;
  logic signed [pid_dd_pkg::SumW:0] sum_wide;
  logic signed [pid_dd_pkg::DutyW-1:0] base_q16, left_v, right_v;

  // configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      max_q    <= '1;
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pid_dd_pkg::CFG_BASE_SPEED: base_q   <= cfg_data_i[pid_dd_pkg::SpdW-1:0];
        pid_dd_pkg::CFG_MAX_SPEED:  max_q    <= cfg_data_i[pid_dd_pkg::SpdW-1:0];
        pid_dd_pkg::CFG_GAIN_P:     gain_p_q <= $signed(cfg_data_i);
        pid_dd_pkg::CFG_GAIN_I:     gain_i_q <= $signed(cfg_data_i);
        pid_dd_pkg::CFG_GAIN_D:     gain_d_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // a register loads when it is empty or its content moves on
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign s1_load    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_load;
  assign accept     = in_valid_i && s1_load;

  // saturating running sum and error difference
  always_comb begin
    sum_wide = (pid_dd_pkg::SumW+1)'(error_sum_q) + (pid_dd_pkg::SumW+1)'(error_i);
    if (sum_wide[pid_dd_pkg::SumW] != sum_wide[pid_dd_pkg::SumW-1]) begin
      error_sum_d = sum_wide[pid_dd_pkg::SumW] ?
                    {1'b1, {(pid_dd_pkg::SumW-1){1'b0}}} :
                    {1'b0, {(pid_dd_pkg::SumW-1){1'b1}}};
    end else begin
      error_sum_d = sum_wide[pid_dd_pkg::SumW-1:0];
    end
    s1_diff_d = pid_dd_pkg::DiffW'(error_i) - pid_dd_pkg::DiffW'(prev_error_q);
  end

  // three gain products
  assign p_prod = pid_dd_pkg::PProdW'(gain_p_q) * pid_dd_pkg::PProdW'(s1_err_q);
  assign i_prod = pid_dd_pkg::IProdW'(gain_i_q) * pid_dd_pkg::IProdW'(s1_sum_q);
  assign d_prod = pid_dd_pkg::DProdW'(gain_d_q) * pid_dd_pkg::DProdW'(s1_diff_q);

  // correction sum
  assign corr = pid_dd_pkg::CorrW'(p_prod) + pid_dd_pkg::CorrW'(i_prod)
              + pid_dd_pkg::CorrW'(d_prod);

  // wheel duties around the base speed
  always_comb begin
    base_q16 = $signed({{(pid_dd_pkg::DutyW-pid_dd_pkg::SpdW-pid_dd_pkg::FracW){1'b0}},
                        base_q, {pid_dd_pkg::FracW{1'b0}}});
    left_v   = base_q16 - pid_dd_pkg::DutyW'(corr);
    right_v  = base_q16 + pid_dd_pkg::DutyW'(corr);
    left_d   = pid_dd_pkg::duty_clamp(left_v, max_q);
    right_d  = pid_dd_pkg::duty_clamp(right_v, max_q);
  end

  // state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      prev_error_q <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        error_sum_q  <= error_sum_d;
        prev_error_q <= error_i;
      end
      if (s1_load) s1_valid_q <= accept;
      if (out_free) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_err_q  <= error_i;
      s1_sum_q  <= error_sum_d;
      s1_diff_q <= s1_diff_d;
    end
    if (s1_move) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;

  // input stalls only when both registers hold a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // accepted error becomes the previous error
  a_prev_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (prev_error_q == $past(error_i)))
    else $error("previous error not updated");

  // a non-negative error never lowers the running sum
  a_sum_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !error_i[pid_dd_pkg::ErrW-1]) |=> (error_sum_q >= $past(error_sum_q)))
    else $error("running sum decreased on non-negative error");

  // duties stay within the clamp
  a_duty_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((left_speed_o <= max_q) && (right_speed_o <= max_q)))
    else $error("wheel duty above max speed");

endmodule

>>> tb/pid_dd_duty_checker.sv
// scoreboard for the differential drive pid block: tracks register writes, predicts wheel duties
// from each accepted error transaction and compares them with the duty channel
// depends on pid_dd_pkg

module pid_dd_duty_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [pid_dd_pkg::ErrW-1:0]    error_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic [pid_dd_pkg::SpdW-1:0]           left_speed_i,
  input  logic [pid_dd_pkg::SpdW-1:0]           right_speed_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [pid_dd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pid_dd_pkg::CfgDataW-1:0]       cfg_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam longint SumMax = (longint'(1) <<< (pid_dd_pkg::SumW - 1)) - 1;
  localparam longint SumMin = -(longint'(1) <<< (pid_dd_pkg::SumW - 1));
  localparam int     MaxReported = 10;

  typedef struct packed {
    logic [pid_dd_pkg::SpdW-1:0] left;
    logic [pid_dd_pkg::SpdW-1:0] right;
  } duty_t;

  // shadow copy of the registers
  logic [pid_dd_pkg::SpdW-1:0]         base_spd;
  logic [pid_dd_pkg::SpdW-1:0]         max_spd;
  logic signed [pid_dd_pkg::GainW-1:0] kp;
  logic signed [pid_dd_pkg::GainW-1:0] ki;
  logic signed [pid_dd_pkg::GainW-1:0] kd;

  // controller state as the block should hold it
  longint err_sum;
  longint prev_err;

  longint cur_err;
  longint err_diff;
  longint correction;
  longint base_q16;
  duty_t  want;
  duty_t  got;
  duty_t  duty_q[$];
  int     n_fail;
  int     n_pending;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  // q.16 wheel value to integer duty, clamped to 0..limit
  function automatic logic [pid_dd_pkg::SpdW-1:0] clamp_duty(
      input longint q16, input logic [pid_dd_pkg::SpdW-1:0] limit);
    logic [pid_dd_pkg::SpdW-1:0] res;
    if (q16 <= 0) begin
      res = '0;
    end else if (q16 >= longint'(limit) * 65536) begin
      res = limit;
    end else begin
      res = q16[pid_dd_pkg::FracW+pid_dd_pkg::SpdW-1:pid_dd_pkg::FracW];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_spd  = '0;
      max_spd   = '1;
      kp        = '0;
      ki        = '0;
      kd        = '0;
      err_sum   = 0;
      prev_err  = 0;
      n_fail    = 0;
      n_pending = 0;
      duty_q.delete();
    end else begin
      // register write transaction
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pid_dd_pkg::CFG_BASE_SPEED: base_spd = cfg_data_i[pid_dd_pkg::SpdW-1:0];
          pid_dd_pkg::CFG_MAX_SPEED:  max_spd  = cfg_data_i[pid_dd_pkg::SpdW-1:0];
          pid_dd_pkg::CFG_GAIN_P:     kp       = cfg_data_i;
          pid_dd_pkg::CFG_GAIN_I:     ki       = cfg_data_i;
          pid_dd_pkg::CFG_GAIN_D:     kd       = cfg_data_i;
          default: ;
        endcase
      end

      // error transaction: update integral and derivative, predict both duties
      if (in_valid_i && !in_stall_i) begin
        cur_err = error_i;
        err_sum = err_sum + cur_err;
        if (err_sum > SumMax) err_sum = SumMax;
        if (err_sum < SumMin) err_sum = SumMin;
        err_diff   = cur_err - prev_err;
        correction = longint'(kp) * cur_err + longint'(ki) * err_sum + longint'(kd) * err_diff;
        prev_err   = cur_err;
        base_q16   = longint'(base_spd) * 65536;
        want.left  = clamp_duty(base_q16 - correction, max_spd);
        want.right = clamp_duty(base_q16 + correction, max_spd);
        duty_q.push_back(want);
        n_pending++;
      end

      // duty transaction: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got.left  = left_speed_i;
        got.right = right_speed_i;
        if (duty_q.size() == 0) begin
          if (n_fail < MaxReported) begin
            $display("unexpected duty transaction: left %0d right %0d", got.left, got.right);
          end
          n_fail++;
        end else begin
          want = duty_q.pop_front();
          n_pending--;
          if (got.left !== want.left || got.right !== want.right) begin
            if (n_fail < MaxReported) begin
              $display("duty mismatch: expected left %0d right %0d, got left %0d right %0d",
                       want.left, want.right, got.left, got.right);
            end
            n_fail++;
          end
        end
      end
    end
  end

endmodule

>>> tb/pid_differential_drive_test.sv
// top of the pid differential drive testbench: clock, reset, register setup, error stimulus
// and the verdict; depends on pid_dd_pkg, pid_differential_drive and pid_dd_duty_checker

module pid_differential_drive_test;

  localparam int ClkPeriod     = 8;
  localparam int TimeoutCycles = 200_000;
  localparam int DrainCycles   = 16;
  localparam int Phases        = 10;
  localparam int PhaseItems    = 95;
  localparam int QuietPhases   = 2;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic signed [pid_dd_pkg::ErrW-1:0]   error = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [pid_dd_pkg::SpdW-1:0]          left_speed;
  logic [pid_dd_pkg::SpdW-1:0]          right_speed;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [pid_dd_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [pid_dd_pkg::CfgDataW-1:0]      cfg_data = '0;
  int                                   fail_count;
  int                                   pending;
  bit                                   no_idle = 1'b0;
  int                                   walk = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  pid_differential_drive u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .error_i       (error),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .left_speed_o  (left_speed),
    .right_speed_o (right_speed),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  pid_dd_duty_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .error_i       (error),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .left_speed_i  (left_speed),
    .right_speed_i (right_speed),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // hard stop if the run hangs
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("== FAIL ==");
    $finish;
  end

  // receiver back-pressure in random bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        hold = $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one register write transaction, valid left high for a following write
  task automatic write_reg(input logic [pid_dd_pkg::CfgIdxW-1:0] idx,
                           input logic [pid_dd_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register setup, optionally followed by writes to unused indexes
  task automatic load_config(input logic [pid_dd_pkg::SpdW-1:0] base,
                             input logic [pid_dd_pkg::SpdW-1:0] top,
                             input logic [pid_dd_pkg::GainW-1:0] kp,
                             input logic [pid_dd_pkg::GainW-1:0] ki,
                             input logic [pid_dd_pkg::GainW-1:0] kd, input bit spare);
    write_reg(pid_dd_pkg::CFG_BASE_SPEED,
              {{(pid_dd_pkg::CfgDataW-pid_dd_pkg::SpdW){1'b0}}, base});
    write_reg(pid_dd_pkg::CFG_MAX_SPEED,
              {{(pid_dd_pkg::CfgDataW-pid_dd_pkg::SpdW){1'b0}}, top});
    write_reg(pid_dd_pkg::CFG_GAIN_P, kp);
    write_reg(pid_dd_pkg::CFG_GAIN_I, ki);
    write_reg(pid_dd_pkg::CFG_GAIN_D, kd);
    if (spare) begin
      for (int k = pid_dd_pkg::CFG_GAIN_D + 1; k < 2 ** pid_dd_pkg::CfgIdxW; k++) begin
        write_reg(k[pid_dd_pkg::CfgIdxW-1:0], pid_dd_pkg::CfgDataW'($urandom));
      end
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one error transaction, with an occasional idle burst ahead of it
  task automatic send_error(input logic signed [pid_dd_pkg::ErrW-1:0] v);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    error    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and let every predicted duty come out
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // gain mix: rails, zero, full range, and small values that keep duties off the clamp
  function automatic logic [pid_dd_pkg::GainW-1:0] pick_gain();
    logic [pid_dd_pkg::GainW-1:0] g;
    case ($urandom_range(0, 7))
      0:       g = 16'h8000;
      1:       g = 16'h7fff;
      2:       g = '0;
      3, 4:    g = pid_dd_pkg::GainW'($urandom);
      default: g = pid_dd_pkg::GainW'(int'($urandom_range(0, 1023)) - 512);
    endcase
    return g;
  endfunction

  // error mix: rails, full random, and a smooth random walk like a real sensor
  function automatic logic signed [pid_dd_pkg::ErrW-1:0] pick_error();
    logic signed [pid_dd_pkg::ErrW-1:0] e;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       e = 16'sh8000;
          1:       e = 16'sh7fff;
          2:       e = 16'sh0001;
          3:       e = 16'shffff;
          default: e = '0;
        endcase
      end
      1, 2: e = pid_dd_pkg::ErrW'($urandom);
      default: begin
        walk = walk + int'($urandom_range(0, 1023)) - 512;
        if (walk > 32767) walk = 32767;
        if (walk < -32768) walk = -32768;
        e = walk[pid_dd_pkg::ErrW-1:0];
      end
    endcase
    return e;
  endfunction

  initial begin
    logic [pid_dd_pkg::SpdW-1:0] base;
    logic [pid_dd_pkg::SpdW-1:0] top;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: base 0 gives zero duty whatever the error
    send_error(16'sh7fff);
    send_error(16'sh8000);
    send_error(16'sh0000);
    drain();

    // proportional only, duty driven past zero and past the clamp
    load_config(8'd100, 8'd200, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_error(16'sh0000);
    send_error(16'sh3200);
    send_error(16'sh7fff);
    send_error(16'sh8000);
    send_error(16'sh0001);
    send_error(16'shffff);
    drain();

    // clamp below base, extreme gains and the widest error difference
    load_config(8'd200, 8'd100, 16'h7fff, 16'h0000, 16'h8000, 1'b0);
    send_error(16'sh0000);
    send_error(16'sh7fff);
    send_error(16'sh8000);
    send_error(16'sh7fff);
    drain();

    // zero clamp
    load_config(8'd255, 8'd0, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_error(16'sh03e8);
    send_error(16'shfc18);
    drain();

    // integral term, then writes to unused indexes must change nothing
    load_config(8'd50, 8'd255, 16'h0000, 16'h0100, 16'h0000, 1'b1);
    send_error(16'sh0100);
    send_error(16'sh0100);
    send_error(16'shfe00);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < Phases; ph++) begin
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = '1;
        default: base = pid_dd_pkg::SpdW'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       top = '0;
        1, 2:    top = '1;
        default: top = pid_dd_pkg::SpdW'($urandom);
      endcase
      load_config(base, top, pick_gain(), pick_gain(), pick_gain(), ph == 0);
      no_idle = (ph >= Phases - QuietPhases);
      repeat (PhaseItems) send_error(pick_error());
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
